// ----- sv/rkcd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and constants of the rotary knob CAN decoder.
package rkcd_pkg;

    localparam int IdWidth    = 11;
    localparam int ByteWidth  = 8;
    localparam int RotWidth   = 16;
    localparam int KindWidth  = 3;
    localparam int IndexWidth = 3;
    localparam int PayWidth   = 64;

    // Frame id fields and recognized codes
    localparam logic [IdWidth-1:0] FuncMask   = 11'h780;
    localparam logic [IdWidth-1:0] NodeMask   = 11'h07F;
    localparam logic [IdWidth-1:0] FuncKnob   = 11'h180;
    localparam logic [IdWidth-1:0] NodeKnobA  = 11'h038;
    localparam logic [IdWidth-1:0] NodeKnobB  = 11'h040;
    localparam logic [IdWidth-1:0] FuncHaptic = 11'h580;

    // Button masks, all bits of a mask must be set for "pressed"
    localparam logic [ByteWidth-1:0] MaskKnob = 8'hC1;
    localparam logic [ByteWidth-1:0] MaskMenu = 8'hC4;
    localparam logic [ByteWidth-1:0] MaskUser = 8'hD0;
    localparam logic [ByteWidth-1:0] HapticReserved = 8'h00;

    // Divider: one quotient bit per cycle
    localparam int DivSteps    = RotWidth;
    localparam int DivCntWidth = $clog2(DivSteps + 1);

    // Result slots, emitted lowest first
    localparam int SlotMain   = 0;
    localparam int SlotKnob   = 1;
    localparam int SlotMenu   = 2;
    localparam int SlotUser   = 3;
    localparam int SlotHaptic = 4;
    localparam int NumSlots   = 5;

    typedef enum logic [KindWidth-1:0] {
        EV_STEP_CHANGE = 3'd0,
        EV_ROTATION    = 3'd1,
        EV_KNOB        = 3'd2,
        EV_MENU        = 3'd3,
        EV_USER        = 3'd4,
        EV_HAPTIC      = 3'd5
    } event_kind_t;

    typedef enum logic [IndexWidth-1:0] {
        CFG_HAPTIC_MODE    = 3'd0,
        CFG_CLICK_HARDNESS = 3'd1,
        CFG_STEP_DISTANCE  = 3'd2,
        CFG_STEP_COUNT     = 3'd3,
        CFG_START_POSITION = 3'd4,
        CFG_HILL_SIZE      = 3'd5,
        CFG_END_RESISTANCE = 3'd6
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIVIDE,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic load;       // capture the input transaction
        logic div_start;  // seed the divider
        logic div_step;   // one quotient bit
        logic snap;       // fix the result set and update state
        logic emit;       // load the next result into the output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_divide;
        logic div_done;
        logic slots_empty;
        logic out_free;
    } dp_status_t;

endpackage

// ----- sv/rkcd_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine of the rotary knob CAN decoder.
module rkcd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  rkcd_pkg::dp_status_t  status,
    output rkcd_pkg::ctrl_cmd_t   cmd
);

    rkcd_pkg::ctrl_state_t state_reg;
    rkcd_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rkcd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            rkcd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = rkcd_pkg::ST_DECODE;
                end
            end
            rkcd_pkg::ST_DECODE:
            begin
                if (status.need_divide)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = rkcd_pkg::ST_DIVIDE;
                end
                else
                begin
                    cmd.snap   = 1'b1;
                    state_next = rkcd_pkg::ST_EMIT;
                end
            end
            rkcd_pkg::ST_DIVIDE:
            begin
                if (status.div_done)
                begin
                    cmd.snap   = 1'b1;
                    state_next = rkcd_pkg::ST_EMIT;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            rkcd_pkg::ST_EMIT:
            begin
                if (status.slots_empty)
                begin
                    state_next = rkcd_pkg::ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                end
            end
            default:
            begin
                state_next = rkcd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/rkcd_datapath.sv -----
`timescale 1ns / 1ps
// Datapath of the rotary knob CAN decoder: config, state, divider, result register.
module rkcd_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rkcd_pkg::ctrl_cmd_t   cmd,
    output rkcd_pkg::dp_status_t  status,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [7:0]            cfg_data,
    input  logic [10:0]           frame_id,
    input  logic [7:0]            payload_byte_one,
    input  logic [7:0]            payload_byte_two,
    input  logic [7:0]            payload_byte_three,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [2:0]            event_kind,
    output logic [7:0]            old_step,
    output logic [7:0]            new_step,
    output logic signed [15:0]    rotation_value,
    output logic                  pressed,
    output logic [15:0]           target_id,
    output logic [63:0]           frame_payload,
    output logic                  last_of_run
);

    // Configuration registers; the start position only loads the step position
    logic [7:0] haptic_mode_reg;
    logic [7:0] click_hardness_reg;
    logic [7:0] step_distance_reg;
    logic [7:0] step_count_reg;
    logic [7:0] hill_size_reg;
    logic [7:0] end_resistance_reg;

    // Block state
    logic [15:0] device_id_reg;
    logic [7:0]  step_position_reg;
    logic [7:0]  button_status_reg;

    // Captured transaction
    logic [10:0] frame_id_reg;
    logic [7:0]  byte_one_reg;
    logic [7:0]  byte_two_reg;
    logic [7:0]  byte_three_reg;

    // Divider
    logic [15:0]                         div_q_reg;
    logic [7:0]                          div_rem_reg;
    logic                                div_neg_reg;
    logic [rkcd_pkg::DivCntWidth-1:0]    div_cnt_reg;
    logic [8:0]                          rem_shift;
    logic                                rem_ge;
    logic [16:0]                         num_sum;

    // Result set
    logic [rkcd_pkg::NumSlots-1:0] slots_reg;
    logic [rkcd_pkg::NumSlots-1:0] slots_next;
    logic                          main_is_rot_reg;
    logic [7:0]                    snap_old_reg;
    logic [7:0]                    snap_new_reg;
    logic [2:0]                    now_reg;

    // Output register
    logic                 out_valid_reg;
    logic [2:0]           kind_reg;
    logic [7:0]           old_step_reg;
    logic [7:0]           new_step_reg;
    logic signed [15:0]   rot_reg;
    logic                 pressed_reg;
    logic [15:0]          target_reg;
    logic [63:0]          payload_reg;
    logic                 last_reg;

    // Decode of the captured frame
    logic        knob_ok;
    logic        haptic_ok;
    logic        sd_zero;
    logic [7:0]  hi_step;
    logic [7:0]  pos;
    logic [2:0]  now_bits;
    logic [2:0]  was_bits;
    logic [63:0] haptic_payload;
    logic        last_now;

    assign knob_ok = ((frame_id_reg & rkcd_pkg::FuncMask) == rkcd_pkg::FuncKnob)
                  && (((frame_id_reg & rkcd_pkg::NodeMask) == rkcd_pkg::NodeKnobA)
                   || ((frame_id_reg & rkcd_pkg::NodeMask) == rkcd_pkg::NodeKnobB));
    assign haptic_ok = (frame_id_reg & rkcd_pkg::FuncMask) == rkcd_pkg::FuncHaptic;
    assign sd_zero   = (step_distance_reg == 8'd0);
    assign hi_step   = (step_count_reg == 8'd0) ? 8'd0 : step_count_reg - 8'd1;

    // Rotation plus half a step, as a 17-bit signed sum
    assign num_sum = {{1{byte_three_reg[7]}}, byte_three_reg, byte_two_reg}
                   + {10'd0, step_distance_reg[7:1]};

    // Negative numerators clamp to zero and quotients above the last step clamp to it
    assign pos = div_neg_reg ? 8'd0
               : (div_q_reg > {8'd0, hi_step}) ? hi_step : div_q_reg[7:0];

    assign now_bits[0] = (byte_one_reg & rkcd_pkg::MaskKnob) == rkcd_pkg::MaskKnob;
    assign now_bits[1] = (byte_one_reg & rkcd_pkg::MaskMenu) == rkcd_pkg::MaskMenu;
    assign now_bits[2] = (byte_one_reg & rkcd_pkg::MaskUser) == rkcd_pkg::MaskUser;
    assign was_bits[0] = (button_status_reg & rkcd_pkg::MaskKnob) == rkcd_pkg::MaskKnob;
    assign was_bits[1] = (button_status_reg & rkcd_pkg::MaskMenu) == rkcd_pkg::MaskMenu;
    assign was_bits[2] = (button_status_reg & rkcd_pkg::MaskUser) == rkcd_pkg::MaskUser;

    always_comb
    begin
        slots_next = '0;
        slots_next[rkcd_pkg::SlotMain] = knob_ok && (sd_zero || (pos != step_position_reg));
        slots_next[rkcd_pkg::SlotKnob] = knob_ok && (now_bits[0] != was_bits[0]);
        slots_next[rkcd_pkg::SlotMenu] = knob_ok && (now_bits[1] != was_bits[1]);
        slots_next[rkcd_pkg::SlotUser] = knob_ok && (now_bits[2] != was_bits[2]);
        slots_next[rkcd_pkg::SlotHaptic] = haptic_ok;
    end

    // Restoring division step
    assign rem_shift = {div_rem_reg, div_q_reg[15]};
    assign rem_ge    = rem_shift >= {1'b0, step_distance_reg};

    assign haptic_payload = {end_resistance_reg, hill_size_reg, rkcd_pkg::HapticReserved,
                             step_position_reg, step_count_reg,
                             4'd0, step_distance_reg[7:4],
                             click_hardness_reg, haptic_mode_reg};

    assign last_now = (slots_reg & (slots_reg - 5'd1)) == '0;

    assign status.need_divide = knob_ok && !sd_zero;
    assign status.div_done    = (div_cnt_reg == '0);
    assign status.slots_empty = (slots_reg == '0);
    assign status.out_free    = !out_valid_reg || out_ready;

    // Configuration and block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            haptic_mode_reg    <= 8'd0;
            click_hardness_reg <= 8'd0;
            step_distance_reg  <= 8'd0;
            step_count_reg     <= 8'd1;
            hill_size_reg      <= 8'd0;
            end_resistance_reg <= 8'd0;
            device_id_reg      <= 16'd0;
            step_position_reg  <= 8'd0;
            button_status_reg  <= 8'd0;
        end
        else
        begin
            if (cmd.snap && knob_ok)
            begin
                if (!sd_zero)
                begin
                    step_position_reg <= pos;
                end
                button_status_reg <= byte_one_reg;
            end
            if (cmd.snap && haptic_ok)
            begin
                device_id_reg <= {byte_one_reg, byte_two_reg};
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    rkcd_pkg::CFG_HAPTIC_MODE:    haptic_mode_reg    <= cfg_data;
                    rkcd_pkg::CFG_CLICK_HARDNESS: click_hardness_reg <= cfg_data;
                    rkcd_pkg::CFG_STEP_DISTANCE:  step_distance_reg  <= cfg_data;
                    rkcd_pkg::CFG_STEP_COUNT:     step_count_reg     <= cfg_data;
                    rkcd_pkg::CFG_START_POSITION: step_position_reg  <= cfg_data;
                    rkcd_pkg::CFG_HILL_SIZE:      hill_size_reg      <= cfg_data;
                    rkcd_pkg::CFG_END_RESISTANCE: end_resistance_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Captured transaction, divider registers and snapshot payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            frame_id_reg   <= frame_id;
            byte_one_reg   <= payload_byte_one;
            byte_two_reg   <= payload_byte_two;
            byte_three_reg <= payload_byte_three;
        end
        if (cmd.div_start)
        begin
            div_q_reg   <= num_sum[15:0];
            div_neg_reg <= num_sum[16];
            div_rem_reg <= 8'd0;
        end
        else if (cmd.div_step)
        begin
            div_q_reg   <= {div_q_reg[14:0], rem_ge};
            div_rem_reg <= rem_ge ? 8'(rem_shift - {1'b0, step_distance_reg})
                                  : rem_shift[7:0];
        end
        if (cmd.snap)
        begin
            main_is_rot_reg <= sd_zero;
            snap_old_reg    <= step_position_reg;
            snap_new_reg    <= pos;
            now_reg         <= now_bits;
        end
    end

    // Control state: divider count, pending slots, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg   <= '0;
            slots_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.div_start)
            begin
                div_cnt_reg <= rkcd_pkg::DivCntWidth'(rkcd_pkg::DivSteps);
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg - rkcd_pkg::DivCntWidth'(1);
            end

            if (cmd.snap)
            begin
                slots_reg <= slots_next;
            end
            else if (cmd.emit)
            begin
                slots_reg <= slots_reg & (slots_reg - 5'd1);
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result register: take the lowest pending slot
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            old_step_reg <= 8'd0;
            new_step_reg <= 8'd0;
            rot_reg      <= 16'sd0;
            pressed_reg  <= 1'b0;
            target_reg   <= 16'd0;
            payload_reg  <= 64'd0;
            last_reg     <= last_now;
            if (slots_reg[rkcd_pkg::SlotMain])
            begin
                if (main_is_rot_reg)
                begin
                    kind_reg <= rkcd_pkg::EV_ROTATION;
                    rot_reg  <= {byte_three_reg, byte_two_reg};
                end
                else
                begin
                    kind_reg     <= rkcd_pkg::EV_STEP_CHANGE;
                    old_step_reg <= snap_old_reg;
                    new_step_reg <= snap_new_reg;
                end
            end
            else if (slots_reg[rkcd_pkg::SlotKnob])
            begin
                kind_reg    <= rkcd_pkg::EV_KNOB;
                pressed_reg <= now_reg[0];
            end
            else if (slots_reg[rkcd_pkg::SlotMenu])
            begin
                kind_reg    <= rkcd_pkg::EV_MENU;
                pressed_reg <= now_reg[1];
            end
            else if (slots_reg[rkcd_pkg::SlotUser])
            begin
                kind_reg    <= rkcd_pkg::EV_USER;
                pressed_reg <= now_reg[2];
            end
            else
            begin
                kind_reg    <= rkcd_pkg::EV_HAPTIC;
                target_reg  <= device_id_reg;
                payload_reg <= haptic_payload;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign event_kind     = kind_reg;
    assign old_step       = old_step_reg;
    assign new_step       = new_step_reg;
    assign rotation_value = rot_reg;
    assign pressed        = pressed_reg;
    assign target_id      = target_reg;
    assign frame_payload  = payload_reg;
    assign last_of_run    = last_reg;

endmodule

// ----- sv/rotary_knob_can_decoder_core.sv -----
`timescale 1ns / 1ps
// Top level of the rotary knob CAN decoder.
//
// Decodes one received CAN frame per input transaction. A knob frame (function
// code 0x180, node 0x38 or 0x40) yields a raw-rotation event (zero step
// distance) or a step-change event when the step position changes, followed
// by up to three button press/release events; a 0x580 frame latches the
// device id and yields one haptic configuration frame; other frames are
// dropped without results. The last result of each frame carries last_of_run.
// Timing: the frame is captured at the accepting edge and decoded in the next
// cycle. With a nonzero step distance, a knob frame then passes through the
// bit-serial restoring divider (one quotient bit per cycle) before the result
// set is fixed; otherwise the result set is fixed in the decode cycle. The
// results are then loaded into the output register one per cycle while the
// consumer does not stall. After the last result is loaded, the controller
// returns to idle and only then accepts the next frame. Configuration writes
// are registered; write them only while idle.
module rotary_knob_can_decoder_core (
    input  logic                clk,
    input  logic                rst_n,
    // Configuration write port
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [7:0]          cfg_data,
    // Frame input channel
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [10:0]         frame_id,
    input  logic [7:0]          payload_byte_one,
    input  logic [7:0]          payload_byte_two,
    input  logic [7:0]          payload_byte_three,
    // Result output channel
    output logic                out_valid,
    input  logic                out_ready,
    output logic [2:0]          event_kind,
    output logic [7:0]          old_step,
    output logic [7:0]          new_step,
    output logic signed [15:0]  rotation_value,
    output logic                pressed,
    output logic [15:0]         target_id,
    output logic [63:0]         frame_payload,
    output logic                last_of_run
);

    rkcd_pkg::ctrl_cmd_t  cmd;
    rkcd_pkg::dp_status_t status;

    // Sequence capture, divide, snapshot and per-result emission
    rkcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Hold config and state, divide, and drive the output register
    rkcd_datapath u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .frame_id           (frame_id),
        .payload_byte_one   (payload_byte_one),
        .payload_byte_two   (payload_byte_two),
        .payload_byte_three (payload_byte_three),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .event_kind         (event_kind),
        .old_step           (old_step),
        .new_step           (new_step),
        .rotation_value     (rotation_value),
        .pressed            (pressed),
        .target_id          (target_id),
        .frame_payload      (frame_payload),
        .last_of_run        (last_of_run)
    );

endmodule
